// File: hw/rtl/multi_tap_keypad_decoder_macros.svh
// Assertion macros for the multi-tap keypad decoder.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MULTI_TAP_KEYPAD_DECODER_MACROS_SVH
`define MULTI_TAP_KEYPAD_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MTKD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtkd check failed");

// Next-cycle implication, checked out of reset.
`define MTKD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtkd check failed");

`endif

// File: hw/rtl/mtkd_pkg.sv
// Package for the multi-tap keypad decoder: key and action codes, state and
// result types, and the letter lookup. No dependencies.
package mtkd_pkg;

  localparam int CNT_W = 13;
  localparam logic [CNT_W-1:0] BUFFER_CHARS = 13'd4096;

  typedef enum logic [2:0] {
    ACT_INSERT  = 3'd0,
    ACT_REPLACE = 3'd1,
    ACT_DELETE  = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_COMMIT  = 3'd4
  } action_t;

  localparam logic [3:0] KEY_SPACE = 4'd0;
  localparam logic [3:0] KEY_ONE   = 4'd1;
  localparam logic [3:0] KEY_TWO   = 4'd2;
  localparam logic [3:0] KEY_THREE = 4'd3;
  localparam logic [3:0] KEY_FOUR  = 4'd4;
  localparam logic [3:0] KEY_FIVE  = 4'd5;
  localparam logic [3:0] KEY_SIX   = 4'd6;
  localparam logic [3:0] KEY_SEVEN = 4'd7;
  localparam logic [3:0] KEY_EIGHT = 4'd8;
  localparam logic [3:0] KEY_NINE  = 4'd9;
  localparam logic [3:0] KEY_CASE  = 4'd10;
  localparam logic [3:0] KEY_BACK  = 4'd11;
  localparam logic [3:0] KEY_CLEAR = 4'd12;

  localparam logic       OP_PRESS = 1'b0;
  localparam logic       OP_TICK  = 1'b1;

  localparam logic [2:0] TAP_TOP_FOUR  = 3'd4;
  localparam logic [2:0] TAP_TOP_THREE = 3'd3;

  localparam logic [7:0]  CHR_SPACE   = 8'h20;
  localparam logic [7:0]  CHR_ONE     = 8'h31;
  localparam logic [7:0]  CHR_ZERO    = 8'h30;
  localparam logic [7:0]  CHR_NONE    = 8'h00;
  localparam logic [7:0]  CASE_OFFSET = 8'h20;
  localparam logic [15:0] IDLE_MAX    = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic [3:0]       last_key;
    logic [2:0]       tap;
    logic             pending;
    logic             capitals;
    logic [15:0]      idle;
    logic [CNT_W-1:0] count;
  } state_t;

  typedef struct packed {
    logic       valid;
    action_t    action;
    logic [7:0] character;
  } result_t;

  function automatic logic [7:0] first_letter(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h41;
      4'd1:    c = 8'h44;
      4'd2:    c = 8'h47;
      4'd3:    c = 8'h4A;
      4'd4:    c = 8'h4D;
      4'd5:    c = 8'h50;
      4'd6:    c = 8'h54;
      4'd7:    c = 8'h57;
      default: c = 8'h5B;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] letter_of(input logic [3:0] key, input logic [2:0] tap,
                                           input logic caps);
    logic [7:0] base;
    logic [7:0] limit;
    logic [7:0] c;
    base  = first_letter({1'b0, 3'(key - 4'd2)});
    limit = first_letter(key - 4'd1);
    c     = base + {5'b0, tap};
    if (c >= limit) begin
      c = CHR_ZERO + {4'b0, key};
    end else if (!caps) begin
      c = c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/mtkd_step.sv
// Next-state and result logic for one keypad transaction.
// Depends on mtkd_pkg.
module mtkd_step (
  input  mtkd_pkg::state_t  cur,
  input  logic [15:0]       timeout,
  input  logic              op,
  input  logic [3:0]        key,
  output mtkd_pkg::state_t  nxt,
  output mtkd_pkg::result_t res
);

  logic                      full;
  logic [15:0]               idle_inc;
  logic [2:0]                top;
  logic [2:0]                tap_nxt;
  logic [mtkd_pkg::CNT_W-1:0] count_inc;

  assign full      = cur.count >= mtkd_pkg::BUFFER_CHARS;
  assign idle_inc  = (cur.idle != mtkd_pkg::IDLE_MAX) ? cur.idle + 16'd1 : cur.idle;
  assign top       = (key == mtkd_pkg::KEY_SEVEN || key == mtkd_pkg::KEY_NINE) ?
                     mtkd_pkg::TAP_TOP_FOUR : mtkd_pkg::TAP_TOP_THREE;
  assign tap_nxt   = (cur.tap >= top) ? 3'd0 : cur.tap + 3'd1;
  assign count_inc = cur.count + {{(mtkd_pkg::CNT_W-1){1'b0}}, 1'b1};

  always_comb begin
    nxt           = cur;
    res.valid     = 1'b0;
    res.action    = mtkd_pkg::ACT_COMMIT;
    res.character = mtkd_pkg::CHR_NONE;
    priority if (op == mtkd_pkg::OP_TICK) begin
      if (cur.pending) begin
        if (idle_inc >= timeout) begin
          nxt.pending = 1'b0;
          nxt.idle    = 16'd0;
          res.valid   = 1'b1;
        end else begin
          nxt.idle = idle_inc;
        end
      end
    end else begin
      unique case (key)
        mtkd_pkg::KEY_TWO, mtkd_pkg::KEY_THREE, mtkd_pkg::KEY_FOUR, mtkd_pkg::KEY_FIVE,
        mtkd_pkg::KEY_SIX, mtkd_pkg::KEY_SEVEN, mtkd_pkg::KEY_EIGHT,
        mtkd_pkg::KEY_NINE: begin
          nxt.idle = 16'd0;
          if (cur.pending && key == cur.last_key) begin
            nxt.tap       = tap_nxt;
            res.valid     = 1'b1;
            res.action    = mtkd_pkg::ACT_REPLACE;
            res.character = mtkd_pkg::letter_of(key, tap_nxt, cur.capitals);
          end else begin
            nxt.tap      = 3'd0;
            nxt.last_key = key;
            nxt.pending  = 1'b0;
            if (full) begin
              res.valid = cur.pending;
            end else begin
              nxt.count     = count_inc;
              nxt.pending   = 1'b1;
              res.valid     = 1'b1;
              res.action    = mtkd_pkg::ACT_INSERT;
              res.character = mtkd_pkg::letter_of(key, 3'd0, cur.capitals);
            end
          end
        end
        mtkd_pkg::KEY_SPACE, mtkd_pkg::KEY_ONE: begin
          nxt.pending = 1'b0;
          nxt.idle    = 16'd0;
          if (full) begin
            res.valid = cur.pending;
          end else begin
            nxt.count     = count_inc;
            res.valid     = 1'b1;
            res.action    = mtkd_pkg::ACT_INSERT;
            res.character = (key == mtkd_pkg::KEY_ONE) ? mtkd_pkg::CHR_ONE :
                            mtkd_pkg::CHR_SPACE;
          end
        end
        mtkd_pkg::KEY_CASE: begin
          nxt.capitals = !cur.capitals;
          nxt.pending  = 1'b0;
          nxt.idle     = 16'd0;
          res.valid    = 1'b1;
        end
        mtkd_pkg::KEY_BACK: begin
          if (cur.count != '0) begin
            nxt.count   = cur.count - {{(mtkd_pkg::CNT_W-1){1'b0}}, 1'b1};
            nxt.pending = 1'b0;
            nxt.idle    = 16'd0;
            res.valid   = 1'b1;
            res.action  = mtkd_pkg::ACT_DELETE;
          end
        end
        mtkd_pkg::KEY_CLEAR: begin
          nxt.count   = '0;
          nxt.pending = 1'b0;
          nxt.idle    = 16'd0;
          res.valid   = 1'b1;
          res.action  = mtkd_pkg::ACT_CLEAR;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/multi_tap_keypad_decoder.sv
// Multi-tap keypad decoder top level: input register, decode state, result register.
// A transaction is captured in the input register, then decoded into the result register.
// Throughput: one per cycle unless out_stall; the single decode step sets the pace.
// Reset (rst_n low, synchronous) clears all state, empties both registers and
// loads the timeout register with 1000. Depends on mtkd_pkg, mtkd_step, macros header.
`include "multi_tap_keypad_decoder_macros.svh"

module multi_tap_keypad_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [3:0]  in_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [7:0]  out_character,
  output logic        out_capital_mode,
  output logic        out_letter_pending,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_timeout_ticks
);

  logic              s1_valid_r;
  logic              s1_op_r;
  logic [3:0]        s1_key_r;
  logic [15:0]       timeout_r;
  mtkd_pkg::state_t  state_r;
  mtkd_pkg::state_t  state_nxt;
  mtkd_pkg::result_t res;
  logic              adv;
  logic              out_valid_r;
  logic [2:0]        out_action_r;
  logic [7:0]        out_character_r;
  logic              out_capital_r;
  logic              out_pending_r;

  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign cfg_ready = 1'b1;

  mtkd_step u_step (
    .cur     (state_r),
    .timeout (timeout_r),
    .op      (s1_op_r),
    .key     (s1_key_r),
    .nxt     (state_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= mtkd_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_timeout_ticks;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r  <= in_op;
      s1_key_r <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_action_r    <= res.action;
      out_character_r <= res.character;
      out_capital_r   <= state_nxt.capitals;
      out_pending_r   <= state_nxt.pending;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_character      = out_character_r;
  assign out_capital_mode   = out_capital_r;
  assign out_letter_pending = out_pending_r;

  `MTKD_ASSERT_NOW(a_tap_range, 1'b1, state_r.tap <= mtkd_pkg::TAP_TOP_FOUR)
  `MTKD_ASSERT_NOW(a_count_range, 1'b1, state_r.count <= mtkd_pkg::BUFFER_CHARS)
  `MTKD_ASSERT_NOW(a_replace_needs_pending, adv && res.valid && res.action == mtkd_pkg::ACT_REPLACE, state_r.pending)
  `MTKD_ASSERT_NOW(a_no_pending_after_edit, out_valid_r && out_action_r != mtkd_pkg::ACT_INSERT && out_action_r != mtkd_pkg::ACT_REPLACE, !out_pending_r)
  `MTKD_ASSERT_NEXT(a_idle_tick_quiet, adv && s1_op_r == mtkd_pkg::OP_TICK && !state_r.pending, !out_valid_r)

endmodule
